### rtl/core/esp3p_pkg.sv
// Shared constants, frame positions and the record type of the radio telegram parser.
`timescale 1ns / 1ps

package esp3p_pkg;

    localparam int POS_W = 5;

    localparam logic [7:0] SYNC_RESET = 8'h55;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_HUNT    = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd2;
    localparam logic [POS_W-1:0] POS_OPT_LEN = 5'd3;
    localparam logic [POS_W-1:0] POS_KIND    = 5'd4;
    localparam logic [POS_W-1:0] POS_HDR_CRC = 5'd5;
    localparam logic [POS_W-1:0] POS_RADIO   = 5'd6;
    localparam logic [POS_W-1:0] POS_AFTER_HDR = 5'd7;
    localparam logic [POS_W-1:0] POS_ID0     = 5'd10;
    localparam logic [POS_W-1:0] POS_ID1     = 5'd11;
    localparam logic [POS_W-1:0] POS_ID2     = 5'd12;
    localparam logic [POS_W-1:0] POS_ID3     = 5'd13;
    localparam logic [POS_W-1:0] POS_PL0     = 5'd14;
    localparam logic [POS_W-1:0] POS_PL1     = 5'd15;
    localparam logic [POS_W-1:0] POS_PL2     = 5'd16;
    localparam logic [POS_W-1:0] POS_RSSI_SHORT = 5'd17;
    localparam logic [POS_W-1:0] POS_RSSI_LONG  = 5'd20;
    localparam logic [POS_W-1:0] POS_MAX     = 5'd31;

    // Telegram types in the low nibble of the radio header
    localparam logic [3:0] TYPE_RPS = 4'h0;
    localparam logic [3:0] TYPE_1BS = 4'h1;
    localparam logic [3:0] TYPE_4BS = 4'h2;

    // ID-length field codes that shorten the header jump
    localparam logic [2:0] IDLEN_NONE = 3'd0;
    localparam logic [2:0] IDLEN_ONE  = 3'd1;
    localparam logic [2:0] IDLEN_TWO  = 3'd2;

    typedef struct packed {
        logic [15:0] packet_length;
        logic [7:0]  option_length;
        logic [7:0]  packet_kind;
        logic [7:0]  header_check;
        logic [7:0]  radio_header;
        logic [31:0] sender_id;
        logic [7:0]  payload_0;
        logic [7:0]  payload_1;
        logic [7:0]  payload_2;
        logic [7:0]  payload_3;
        logic [7:0]  signal_level;
        logic        extended_header;
    } record_t;

endpackage

### rtl/core/esp3p_ifaces.sv
// Valid/ready channel interfaces for serial bytes and decoded telegram records.
`timescale 1ns / 1ps

interface esp3p_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface esp3p_record_if;
    logic        valid;
    logic        ready;
    logic [15:0] packet_length;
    logic [7:0]  option_length;
    logic [7:0]  packet_kind;
    logic [7:0]  header_check;
    logic [7:0]  radio_header;
    logic [31:0] sender_id;
    logic [7:0]  payload_0;
    logic [7:0]  payload_1;
    logic [7:0]  payload_2;
    logic [7:0]  payload_3;
    logic [7:0]  signal_level;
    logic        extended_header;

    modport source (
        output valid, output packet_length, output option_length, output packet_kind,
        output header_check, output radio_header, output sender_id, output payload_0,
        output payload_1, output payload_2, output payload_3, output signal_level,
        output extended_header, input ready
    );
    modport sink (
        input valid, input packet_length, input option_length, input packet_kind,
        input header_check, input radio_header, input sender_id, input payload_0,
        input payload_1, input payload_2, input payload_3, input signal_level,
        input extended_header, output ready
    );
endinterface

### rtl/core/esp3p_decode.sv
// Position counter and capture registers that walk one frame byte by byte.
`timescale 1ns / 1ps

module esp3p_decode
    import esp3p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] sync_byte,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       emit,
    output record_t    rec
);

    logic [POS_W-1:0] position_reg, position_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [7:0]  opt_len_reg, opt_len_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  hdr_crc_reg, hdr_crc_next;
    logic [7:0]  header_reg, header_next;
    logic [31:0] id_reg, id_next;
    logic [7:0]  pl0_reg, pl0_next;
    logic [7:0]  pl1_reg, pl1_next;
    logic [7:0]  pl2_reg, pl2_next;
    logic [7:0]  pl3_reg, pl3_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic        ext_reg, ext_next;

    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] jump;
    logic [2:0]       idlen;
    logic [3:0]       hdr_type;
    logic             short_type;

    always_comb
    begin
        pos_eff    = restart ? POS_HUNT : position_reg;
        pos_inc    = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 5'd1;
        hdr_type   = header_reg[3:0];
        short_type = (hdr_type == TYPE_RPS) || (hdr_type == TYPE_1BS);
        idlen      = data_byte[7:5];

        // Skip the optional header bytes that the radio header announces
        jump = POS_AFTER_HDR;
        if (!data_byte[4])
        begin
            jump = jump + 5'd1;
        end
        if (idlen == IDLEN_NONE)
        begin
            jump = jump + 5'd3;
        end
        else if ((idlen == IDLEN_ONE) || (idlen == IDLEN_TWO))
        begin
            jump = jump + 5'd2;
        end

        position_next = pos_inc;
        len_hi_next   = len_hi_reg;
        len_lo_next   = len_lo_reg;
        opt_len_next  = opt_len_reg;
        kind_next     = kind_reg;
        hdr_crc_next  = hdr_crc_reg;
        header_next   = header_reg;
        id_next       = id_reg;
        pl0_next      = pl0_reg;
        pl1_next      = pl1_reg;
        pl2_next      = pl2_reg;
        pl3_next      = pl3_reg;
        rssi_next     = rssi_reg;
        ext_next      = ext_reg;
        emit          = 1'b0;

        case (pos_eff)
            POS_HUNT:
            begin
                position_next = (data_byte == sync_byte) ? POS_LEN_HI : POS_HUNT;
            end
            POS_LEN_HI:  len_hi_next  = data_byte;
            POS_LEN_LO:  len_lo_next  = data_byte;
            POS_OPT_LEN: opt_len_next = data_byte;
            POS_KIND:    kind_next    = data_byte;
            POS_HDR_CRC: hdr_crc_next = data_byte;
            POS_RADIO:
            begin
                header_next   = data_byte;
                ext_next      = data_byte[4];
                position_next = jump;
            end
            POS_ID0: id_next[31:24] = data_byte;
            POS_ID1: id_next[23:16] = data_byte;
            POS_ID2: id_next[15:8]  = data_byte;
            POS_ID3: id_next[7:0]   = data_byte;
            POS_PL0: pl0_next = data_byte;
            POS_PL1: pl1_next = data_byte;
            POS_PL2: pl2_next = data_byte;
            POS_RSSI_SHORT:
            begin
                if (short_type)
                begin
                    rssi_next = data_byte;
                    emit      = accept;
                end
                else
                begin
                    pl3_next = data_byte;
                end
            end
            POS_RSSI_LONG:
            begin
                rssi_next = data_byte;
                emit      = accept && (short_type || (hdr_type == TYPE_4BS));
            end
            default: position_next = pos_inc;
        endcase

        rec.packet_length   = {len_hi_next, len_lo_next};
        rec.option_length   = opt_len_next;
        rec.packet_kind     = kind_next;
        rec.header_check    = hdr_crc_next;
        rec.radio_header    = header_next;
        rec.sender_id       = id_next;
        rec.payload_0       = pl0_next;
        rec.payload_1       = pl1_next;
        rec.payload_2       = pl2_next;
        rec.payload_3       = pl3_next;
        rec.signal_level    = rssi_next;
        rec.extended_header = ext_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= POS_HUNT;
            len_hi_reg   <= '0;
            len_lo_reg   <= '0;
            opt_len_reg  <= '0;
            kind_reg     <= '0;
            hdr_crc_reg  <= '0;
            header_reg   <= '0;
            id_reg       <= '0;
            pl0_reg      <= '0;
            pl1_reg      <= '0;
            pl2_reg      <= '0;
            pl3_reg      <= '0;
            rssi_reg     <= '0;
            ext_reg      <= 1'b0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            len_hi_reg   <= len_hi_next;
            len_lo_reg   <= len_lo_next;
            opt_len_reg  <= opt_len_next;
            kind_reg     <= kind_next;
            hdr_crc_reg  <= hdr_crc_next;
            header_reg   <= header_next;
            id_reg       <= id_next;
            pl0_reg      <= pl0_next;
            pl1_reg      <= pl1_next;
            pl2_reg      <= pl2_next;
            pl3_reg      <= pl3_next;
            rssi_reg     <= rssi_next;
            ext_reg      <= ext_next;
        end
    end

    a_emit_at_rssi: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (pos_eff == POS_RSSI_SHORT || pos_eff == POS_RSSI_LONG))
        else $error("record emitted away from an RSSI position");

    a_restart_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart && data_byte != sync_byte) |=> (position_reg == POS_HUNT))
        else $error("restart did not return to sync hunt");

    a_header_jump: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_eff == POS_RADIO) |=>
            (position_reg >= POS_AFTER_HDR && position_reg <= POS_ID1))
        else $error("header jump left the 7 to 11 range");

endmodule

### rtl/core/esp3p_out_buf.sv
// Two-entry record queue that decouples the decoder from the record sink.
`timescale 1ns / 1ps

module esp3p_out_buf
    import esp3p_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    output logic    space,
    output logic    pop_valid,
    input  logic    pop_ready,
    output record_t pop_rec
);

    record_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop_rec   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == 2'd2) |-> pop)
        else $error("record pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count did not drop after a lone pop");

endmodule

### rtl/core/esp3_radio_telegram_parser.sv
// Top level of the serial radio telegram parser: config register, decoder and record queue.
//
//   channel  | dir  | handshake        | carries
//   ---------+------+------------------+---------------------------------------
//   serial   | sink | valid / ready    | data_byte, restart
//   record   | src  | valid / ready    | decoded telegram fields
//   cfg      | sink | cfg_we           | cfg_wdata -> sync byte (reset 0x55)
//
// One byte per cycle while the queue has space: each accepted byte updates the
// position counter and capture registers in the same cycle; records join a two-entry queue.
// A record entering an empty queue is on the record channel the cycle after its RSSI byte.
// serial.ready drops only when both queue entries hold untaken records.
// Reset clears the position, capture registers and queue; sync byte returns to 0x55.
`timescale 1ns / 1ps

module esp3_radio_telegram_parser
    import esp3p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    esp3p_byte_if.sink     serial,
    esp3p_record_if.source record
);

    logic [7:0] sync_reg;
    logic       accept;
    logic       emit;
    logic       space;
    record_t    dec_rec;
    record_t    out_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_we)
        begin
            sync_reg <= cfg_wdata;
        end
    end

    assign serial.ready = space;
    assign accept       = serial.valid && space;

    esp3p_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .sync_byte (sync_reg),
        .accept    (accept),
        .data_byte (serial.data_byte),
        .restart   (serial.restart),
        .emit      (emit),
        .rec       (dec_rec)
    );

    esp3p_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_rec  (dec_rec),
        .space     (space),
        .pop_valid (record.valid),
        .pop_ready (record.ready),
        .pop_rec   (out_rec)
    );

    assign record.packet_length   = out_rec.packet_length;
    assign record.option_length   = out_rec.option_length;
    assign record.packet_kind     = out_rec.packet_kind;
    assign record.header_check    = out_rec.header_check;
    assign record.radio_header    = out_rec.radio_header;
    assign record.sender_id       = out_rec.sender_id;
    assign record.payload_0       = out_rec.payload_0;
    assign record.payload_1       = out_rec.payload_1;
    assign record.payload_2       = out_rec.payload_2;
    assign record.payload_3       = out_rec.payload_3;
    assign record.signal_level    = out_rec.signal_level;
    assign record.extended_header = out_rec.extended_header;

endmodule
